>>> design/assert_macros.svh
// Assertion macros shared by the RTL: clocked implication checks on clk, disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: ante |-> cons.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);
// Next-cycle implication: ante |=> cons.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/bq_tdf2_pkg.sv
// Package for the transposed direct form II biquad: widths, register codes, sequencer states.
package bq_tdf2_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_FRAC  = 20;
  localparam int COEF_W     = 24;
  localparam int ACC_W      = 48;
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;
  localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = S_TDATA_W;
  localparam int M_TUSER_W  = 1;

  // Unity gain, or the largest positive coefficient where unity does not fit.
  localparam logic signed [COEF_W-1:0] COEF_UNITY =
    COEF_W'((COEF_FRAC >= COEF_W - 1) ? (2 ** (COEF_W - 1)) - 1 : 2 ** COEF_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0 = 3'd0,
    REG_FF1 = 3'd1,
    REG_FF2 = 3'd2,
    REG_FB1 = 3'd3,
    REG_FB2 = 3'd4
  } cfg_reg_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL0 = 8'b0000_0010,
    ST_ACC0 = 8'b0000_0100,
    ST_RND  = 8'b0000_1000,
    ST_SUM1 = 8'b0001_0000,
    ST_SUB1 = 8'b0010_0000,
    ST_SUM2 = 8'b0100_0000,
    ST_SUB2 = 8'b1000_0000
  } state_t;

endpackage

>>> design/biquad_filter_tdf2_unit.sv
// Top level of the biquad filter: one shared multiplier and adder under a one-hot sequencer.
//
//   channel   dir  handshake                  payload
//   s_        in   s_tvalid / s_tready        s_tdata: sample_in
//   m_        out  m_tvalid / m_tready        m_tdata: sample_out, m_tuser: clipped
//   cfg_      in   cfg_valid / cfg_ready      cfg_index (register), cfg_data (coefficient)
//
// Each beat is accepted in idle, then runs seven sequencer steps, set by the five products
// that all go through the one multiplier (product registered before use). The last step
// loads the result into the output register and waits while that register holds an
// untaken beat, so back pressure holds the sequencer. s_tready is high only in idle.
// cfg_ready is always high; writes are to come while idle, but the block does not check.
// Reset (rst, synchronous) clears both delay accumulators and gives unity pass-through.
`include "assert_macros.svh"

module biquad_filter_tdf2_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bq_tdf2_pkg::S_TDATA_W-1:0]   s_tdata,   // [SAMPLE_W-1:0] sample_in
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bq_tdf2_pkg::M_TDATA_W-1:0]   m_tdata,   // [SAMPLE_W-1:0] sample_out
  output logic [bq_tdf2_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] clipped
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bq_tdf2_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bq_tdf2_pkg::COEF_W-1:0]      cfg_data
);

  localparam int SAMPLE_W  = bq_tdf2_pkg::SAMPLE_W;
  localparam int COEF_W    = bq_tdf2_pkg::COEF_W;
  localparam int ACC_W     = bq_tdf2_pkg::ACC_W;
  localparam int PROD_W    = bq_tdf2_pkg::PROD_W;
  localparam int SUM_W     = bq_tdf2_pkg::SUM_W;
  localparam int COEF_FRAC = bq_tdf2_pkg::COEF_FRAC;

  // Limits widened to the adder width for compares.
  localparam logic signed [SUM_W-1:0] Y_MAX =
    {{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] Y_MIN   = ~Y_MAX;
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  bq_tdf2_pkg::state_t state, state_next;

  // coefficient registers
  logic signed [COEF_W-1:0] coef_ff0, coef_ff1, coef_ff2, coef_fb1, coef_fb2;

  // filter state and datapath registers
  logic signed [ACC_W-1:0]    delay_acc_one, delay_acc_two;
  logic signed [SAMPLE_W-1:0] x_reg, y_reg;
  logic                       clip_hold;     // clip flag of y_reg until the output takes it
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    sum;

  // output register
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_clip;
  logic                       out_valid;

  // shared multiplier
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic                       mul_en;
  logic signed [PROD_W-1:0]   prod_next;

  // shared adder
  logic signed [SUM_W-1:0] add_a, add_b, add_res;
  logic                    add_sub;
  logic                    sum_en;

  // rounding and saturation
  logic signed [SUM_W-1:0]    rnd_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       y_clip;
  logic                       out_free;
  logic                       in_beat;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ACC_MAX) begin
      r = ACC_MAX[ACC_W-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[ACC_W-1:0];
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  assign in_beat   = s_tvalid && s_tready;
  assign s_tready  = (state == bq_tdf2_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;

  // Operand selection per step.
  always_comb begin
    mul_a   = x_reg;
    mul_b   = coef_ff0;
    mul_en  = 1'b0;
    add_a   = SUM_W'(prod);
    add_b   = '0;
    add_sub = 1'b0;
    sum_en  = 1'b0;
    unique case (state)
      bq_tdf2_pkg::ST_IDLE: begin
      end
      bq_tdf2_pkg::ST_MUL0: begin
        mul_en = 1'b1;
      end
      bq_tdf2_pkg::ST_ACC0: begin            // acc = x*ff0 + d1
        mul_b  = coef_ff1;
        mul_en = 1'b1;
        add_b  = SUM_W'(delay_acc_one);
        sum_en = 1'b1;
      end
      bq_tdf2_pkg::ST_RND: begin             // acc + half, product x*ff1 held
        add_a = sum;
        add_b = HALF;
      end
      bq_tdf2_pkg::ST_SUM1: begin            // x*ff1 + d2
        mul_a  = y_reg;
        mul_b  = coef_fb1;
        mul_en = 1'b1;
        add_b  = SUM_W'(delay_acc_two);
        sum_en = 1'b1;
      end
      bq_tdf2_pkg::ST_SUB1: begin            // ... - fb1*y
        mul_b   = coef_ff2;
        mul_en  = 1'b1;
        add_a   = sum;
        add_b   = SUM_W'(prod);
        add_sub = 1'b1;
        sum_en  = 1'b1;
      end
      bq_tdf2_pkg::ST_SUM2: begin            // sum = x*ff2, start fb2*y
        mul_a  = y_reg;
        mul_b  = coef_fb2;
        mul_en = 1'b1;
        sum_en = 1'b1;
      end
      bq_tdf2_pkg::ST_SUB2: begin            // x*ff2 - fb2*y
        add_a   = sum;
        add_b   = SUM_W'(prod);
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign add_res   = add_a + (add_sub ? ~add_b : add_b) + {{(SUM_W - 1){1'b0}}, add_sub};

  // Round half up, then clamp to the sample range.
  assign rnd_full = add_res >>> COEF_FRAC;
  always_comb begin
    y_clip = 1'b1;
    if (rnd_full > Y_MAX) begin
      y_sat = SAMPLE_MAX;
    end else if (rnd_full < Y_MIN) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat  = rnd_full[SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bq_tdf2_pkg::ST_IDLE: if (in_beat) state_next = bq_tdf2_pkg::ST_MUL0;
      bq_tdf2_pkg::ST_MUL0: state_next = bq_tdf2_pkg::ST_ACC0;
      bq_tdf2_pkg::ST_ACC0: state_next = bq_tdf2_pkg::ST_RND;
      bq_tdf2_pkg::ST_RND:  state_next = bq_tdf2_pkg::ST_SUM1;
      bq_tdf2_pkg::ST_SUM1: state_next = bq_tdf2_pkg::ST_SUB1;
      bq_tdf2_pkg::ST_SUB1: state_next = bq_tdf2_pkg::ST_SUM2;
      bq_tdf2_pkg::ST_SUM2: state_next = bq_tdf2_pkg::ST_SUB2;
      bq_tdf2_pkg::ST_SUB2: if (out_free) state_next = bq_tdf2_pkg::ST_IDLE;
      default:              state_next = bq_tdf2_pkg::ST_IDLE;
    endcase
  end

  // control, coefficients and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bq_tdf2_pkg::ST_IDLE;
      out_valid     <= 1'b0;
      delay_acc_one <= '0;
      delay_acc_two <= '0;
      coef_ff0      <= bq_tdf2_pkg::COEF_UNITY;
      coef_ff1      <= '0;
      coef_ff2      <= '0;
      coef_fb1      <= '0;
      coef_fb2      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (bq_tdf2_pkg::cfg_reg_t'(cfg_index))
          bq_tdf2_pkg::REG_FF0: coef_ff0 <= cfg_data;
          bq_tdf2_pkg::REG_FF1: coef_ff1 <= cfg_data;
          bq_tdf2_pkg::REG_FF2: coef_ff2 <= cfg_data;
          bq_tdf2_pkg::REG_FB1: coef_fb1 <= cfg_data;
          bq_tdf2_pkg::REG_FB2: coef_fb2 <= cfg_data;
          default: begin                     // index past the list: ignored
          end
        endcase
      end
      if (state == bq_tdf2_pkg::ST_SUM2) begin
        delay_acc_one <= sat_acc(sum);
      end
      if (state == bq_tdf2_pkg::ST_SUB2 && out_free) begin
        delay_acc_two <= sat_acc(add_res);
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      x_reg <= s_tdata[SAMPLE_W-1:0];
    end
    if (mul_en) begin
      prod <= prod_next;
    end
    if (sum_en) begin
      sum <= add_res;
    end
    if (state == bq_tdf2_pkg::ST_RND) begin
      y_reg     <= y_sat;
      clip_hold <= y_clip;
    end
    if (state == bq_tdf2_pkg::ST_SUB2 && out_free) begin
      out_sample <= y_reg;
      out_clip   <= clip_hold;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = bq_tdf2_pkg::M_TDATA_W'($unsigned(out_sample));
  assign m_tuser  = out_clip;

  // an accepted beat walks the sequencer through its steps to the last step
  `ASSERT_IMP(a_seq_len, in_beat, ##7 (state == bq_tdf2_pkg::ST_SUB2), "sequencer length slip")
  // last step with a free output slot always presents a result
  `ASSERT_NEXT(a_out_load, (state == bq_tdf2_pkg::ST_SUB2) && out_free, m_tvalid, "result not loaded")
  // a clipped result sits at one of the range limits
  `ASSERT_IMP(a_clip_lim, m_tvalid && out_clip, (out_sample == SAMPLE_MAX) || (out_sample == SAMPLE_MIN), "clip flag off limit")

endmodule

>>> tb/biquad_filter_tdf2_checker.sv
// Checker for the biquad filter: mirrors the coefficients, predicts every output beat, compares.
module biquad_filter_tdf2_checker
  import bq_tdf2_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic [M_TUSER_W-1:0]  m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_data,
  output int                    mismatch_count,
  output int                    results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef struct packed {
    sample_t sample;
    logic    clipped;
  } filtered_beat_t;

  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint ACC_HI    = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);

  coef_t          coef_q [NUM_COEFS];
  longint         delay_one;
  longint         delay_two;
  filtered_beat_t filtered_due [$];
  filtered_beat_t want;
  int             errors_seen = 0;
  int             beats_seen = 0;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  function automatic longint saturate(input longint v, input longint hi, output logic hit);
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      hit = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  // One filter step: output from ff0 and the first accumulator, then both
  // accumulators advance with the rounded, saturated output as feedback.
  function automatic filtered_beat_t filter_step(input sample_t x);
    longint         xs;
    longint         acc;
    longint         y;
    logic           clip;
    logic           acc_hit;
    filtered_beat_t r;
    xs  = longint'(x);
    acc = xs * longint'(coef_q[REG_FF0]) + delay_one;
    y   = saturate((acc + ROUND_HALF) >>> COEF_FRAC, SAMPLE_HI, clip);
    delay_one = saturate(xs * longint'(coef_q[REG_FF1]) + delay_two
                         - longint'(coef_q[REG_FB1]) * y, ACC_HI, acc_hit);
    delay_two = saturate(xs * longint'(coef_q[REG_FF2])
                         - longint'(coef_q[REG_FB2]) * y, ACC_HI, acc_hit);
    r.sample  = sample_t'(y);
    r.clipped = clip;
    return r;
  endfunction

  function automatic void log_error(input string what);
    errors_seen++;
    if (errors_seen <= 10)
      $display("[%0t] output beat %0d: %s", $realtime, beats_seen, what);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coef_q[REG_FF0] = COEF_UNITY;
      coef_q[REG_FF1] = '0;
      coef_q[REG_FF2] = '0;
      coef_q[REG_FB1] = '0;
      coef_q[REG_FB2] = '0;
      delay_one = 0;
      delay_two = 0;
      filtered_due.delete();
    end else begin
      // indexes past the last coefficient are dropped by the block
      if (cfg_valid && cfg_ready && cfg_index < NUM_COEFS)
        coef_q[cfg_index] = cfg_data;
      if (s_tvalid && s_tready)
        filtered_due.push_back(filter_step(sample_t'(s_tdata[SAMPLE_W-1:0])));
      if (m_tvalid && m_tready) begin
        if (filtered_due.size() == 0) begin
          log_error($sformatf("unexpected beat sample_out=%0d clipped=%0b",
                              $signed(m_tdata[SAMPLE_W-1:0]), m_tuser[0]));
        end else begin
          want = filtered_due.pop_front();
          if (m_tdata[SAMPLE_W-1:0] !== want.sample || m_tuser[0] !== want.clipped)
            log_error($sformatf("expected sample_out=%0d clipped=%0b, got sample_out=%0d clipped=%0b",
                                want.sample, want.clipped,
                                $signed(m_tdata[SAMPLE_W-1:0]), m_tuser[0]));
        end
        beats_seen++;
      end
    end
    results_due    <= filtered_due.size();
    mismatch_count <= errors_seen;
  end

endmodule

>>> tb/biquad_filter_tdf2_unit_tb.sv
// Testbench top for the biquad filter: clock, reset, stimulus, back pressure and verdict.
module biquad_filter_tdf2_unit_tb;
  import bq_tdf2_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam coef_t   C_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam coef_t   C_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam coef_t   C_HALF = coef_t'(1 << (COEF_FRAC - 1));  // 0.5 in Q4.20
  localparam coef_t   C_ZERO = '0;

  localparam int IDLE_PCT        = 16;    // idle chance per cycle on either side
  localparam int SINK_HOLD_CYCLES = 200;  // one long receiver stall
  localparam int STALL_LIMIT     = 2000;  // cycles with no beat on any channel
  localparam int END_SETTLE      = 32;    // settling wait after the last beat

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;        // [SAMPLE_W-1:0] sample_in
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;             // [SAMPLE_W-1:0] sample_out
  logic [M_TUSER_W-1:0] m_tuser;             // [0] clipped
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  // stimulus-to-sink controls, both driven with NBAs at the clock edge
  logic                 steady_flow = 1'b0;  // no idling on either side
  logic                 sink_hold_req = 1'b0;

  int                   mismatch_count;
  int                   results_due;
  int                   stall_cycles = 0;
  sample_t              batch [$];

  biquad_filter_tdf2_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  biquad_filter_tdf2_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost result shows up as a long quiet stretch.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random idling, one long hold on request so the block backs up
  // into s_tready while the sender keeps offering beats.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (sink_hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
    end
  end

  // Offer one sample and return on the edge it is taken. tvalid stays high on
  // return so back-to-back beats never drop it within one time step.
  task automatic send_sample(input sample_t x);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(x[SAMPLE_W-1:0]);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_batch();
    foreach (batch[i]) send_sample(batch[i]);
  endtask

  // Stop offering and wait until every predicted beat has come out; the
  // block is idle afterward, so coefficient writes are safe.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All five coefficients, optionally followed by a write to an unused index
  // that the block must ignore.
  task automatic load_coefs(input coef_t ff0, input coef_t ff1, input coef_t ff2,
                            input coef_t fb1, input coef_t fb2, input bit stray);
    write_reg(REG_FF0, ff0);
    write_reg(REG_FF1, ff1);
    write_reg(REG_FF2, ff2);
    write_reg(REG_FB1, fb1);
    write_reg(REG_FB2, fb2);
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_COEFS)), coef_t'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  function automatic coef_t rand_coef(input int span);
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly full-range samples, with small values, powers of two and the rails mixed in.
  function automatic sample_t pick_sample();
    int unsigned roll;
    sample_t     p;
    roll = $urandom_range(99);
    if (roll < 60)
      return sample_t'($urandom());
    if (roll < 80)
      return sample_t'(int'($urandom_range(0, 4096)) - 2048);
    if (roll < 90) begin
      p = sample_t'(1 << $urandom_range(SAMPLE_W - 2));
      return ($urandom_range(1) != 0) ? -p : p;
    end
    case ($urandom_range(3))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_sample(pick_sample());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients: unity pass-through, rails and bit patterns.
    batch = '{S_MAX, S_MIN, sample_t'(0), sample_t'(1), sample_t'(-1),
              sample_t'(24'h555555), sample_t'(24'haaaaaa)};
    send_batch();
    drain();

    // Gain of one half: exact ties must round toward plus infinity.
    load_coefs(C_HALF, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
    batch = '{sample_t'(1), sample_t'(-1), sample_t'(3), sample_t'(-3)};
    send_batch();
    drain();

    // Coefficient rails: output clips both ways, accumulators hit their clamps.
    load_coefs(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
    batch = '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, sample_t'(0)};
    send_batch();
    drain();

    load_coefs(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0);
    batch = '{S_MIN, S_MAX, sample_t'(1), sample_t'(-1), sample_t'(0)};
    send_batch();
    drain();

    // Moderate filter with a long receiver hold so the block stalls its input.
    load_coefs(rand_coef(1 << 20), rand_coef(1 << 20), rand_coef(1 << 20),
               rand_coef(1 << 21), coef_t'($urandom_range(0, 1 << 20)), 1'b0);
    sink_hold_req <= 1'b1;
    run_random(120);

    // Full-range coefficients with no idling on either side.
    load_coefs(coef_t'($urandom()), coef_t'($urandom()), coef_t'($urandom()),
               coef_t'($urandom()), coef_t'($urandom()), 1'b1);
    steady_flow <= 1'b1;
    run_random(100);
    steady_flow <= 1'b0;

    // Back to pass-through by explicit writes.
    load_coefs(COEF_UNITY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
    run_random(80);

    load_coefs(rand_coef(1 << 20), rand_coef(1 << 20), rand_coef(1 << 20),
               rand_coef(1 << 21), coef_t'($urandom_range(0, 1 << 20)), 1'b1);
    run_random(130);

    load_coefs(coef_t'($urandom()), coef_t'($urandom()), coef_t'($urandom()),
               coef_t'($urandom()), coef_t'($urandom()), 1'b1);
    run_random(120);

    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
